[rtl/core/gcp_pkg.sv]
// gcp_pkg: types and constants shared by the gerber command stream parser
// parse mode codes, target codes, result kinds, ascii codes and the step structs
// no dependencies
`default_nettype none

package gcp_pkg;

    // parse modes
    localparam logic [3:0] PM_IDLE   = 4'd0;
    localparam logic [3:0] PM_G1     = 4'd1;
    localparam logic [3:0] PM_G2     = 4'd2;
    localparam logic [3:0] PM_M1     = 4'd3;
    localparam logic [3:0] PM_M2     = 4'd4;
    localparam logic [3:0] PM_SKIP   = 4'd5;
    localparam logic [3:0] PM_G54D   = 4'd6;
    localparam logic [3:0] PM_NSTART = 4'd7;
    localparam logic [3:0] PM_NDIG   = 4'd8;
    localparam logic [3:0] PM_PCT    = 4'd9;

    // number targets
    localparam logic [2:0] TG_X   = 3'd0;
    localparam logic [2:0] TG_Y   = 3'd1;
    localparam logic [2:0] TG_I   = 3'd2;
    localparam logic [2:0] TG_J   = 3'd3;
    localparam logic [2:0] TG_D   = 3'd4;
    localparam logic [2:0] TG_G54 = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_SEG      = 3'd0;
    localparam logic [2:0] KIND_END      = 3'd1;
    localparam logic [2:0] KIND_BAD_G    = 3'd2;
    localparam logic [2:0] KIND_G54_NO_D = 3'd3;
    localparam logic [2:0] KIND_BAD_TOOL = 3'd4;
    localparam logic [2:0] KIND_BAD_M    = 3'd5;

    // interpolation modes
    localparam logic [2:0] IM_LIN_X1   = 3'd0;
    localparam logic [2:0] IM_LIN_X10  = 3'd1;
    localparam logic [2:0] IM_LIN_X0P1 = 3'd2;
    localparam logic [2:0] IM_LIN_X001 = 3'd3;
    localparam logic [2:0] IM_CW       = 3'd4;
    localparam logic [2:0] IM_CCW      = 3'd5;
    localparam logic [2:0] IM_FULL_CW  = 3'd6;
    localparam logic [2:0] IM_FULL_CCW = 3'd7;

    // exposure
    localparam logic [1:0] EXP_OFF   = 2'd0;
    localparam logic [1:0] EXP_ON    = 2'd1;
    localparam logic [1:0] EXP_FLASH = 2'd2;

    // ascii
    localparam logic [7:0] CH_G     = "G";
    localparam logic [7:0] CH_M     = "M";
    localparam logic [7:0] CH_D     = "D";
    localparam logic [7:0] CH_X     = "X";
    localparam logic [7:0] CH_Y     = "Y";
    localparam logic [7:0] CH_I     = "I";
    localparam logic [7:0] CH_J     = "J";
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_1     = "1";
    localparam logic [7:0] CH_2     = "2";
    localparam logic [7:0] CH_9     = "9";

    // two digit codes
    localparam logic [15:0] CODE_00 = "00";
    localparam logic [15:0] CODE_01 = "01";
    localparam logic [15:0] CODE_02 = "02";
    localparam logic [15:0] CODE_03 = "03";
    localparam logic [15:0] CODE_04 = "04";
    localparam logic [15:0] CODE_10 = "10";
    localparam logic [15:0] CODE_11 = "11";
    localparam logic [15:0] CODE_12 = "12";
    localparam logic [15:0] CODE_36 = "36";
    localparam logic [15:0] CODE_37 = "37";
    localparam logic [15:0] CODE_54 = "54";
    localparam logic [15:0] CODE_70 = "70";
    localparam logic [15:0] CODE_71 = "71";
    localparam logic [15:0] CODE_74 = "74";
    localparam logic [15:0] CODE_75 = "75";
    localparam logic [15:0] CODE_90 = "90";
    localparam logic [15:0] CODE_91 = "91";

    typedef struct packed {
        logic [3:0] mode;
        logic       neg;
        logic [2:0] target;
        logic [7:0] first;
        logic [9:0] tool;
        logic [1:0] expo;
        logic [2:0] interp;
        logic       changed;
        logic       halted;
    } ctl_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] center_dx;
        logic signed [31:0] center_dy;
        logic [2:0]         interp_mode;
        logic [9:0]         tool_number;
        logic [1:0]         exposure;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/gcp_step.sv]
// gcp_step: combinational work for one byte, from parser state to next state and result
// the byte that ends a number is folded into the same pass
// depends on gcp_pkg
`default_nettype none

module gcp_step
    import gcp_pkg::*;
#(
    parameter int FIRST_TOOL = 10,
    parameter int LAST_TOOL  = 999,
    parameter int COORD_BITS = 32
) (
    input  wire logic [7:0]            in_byte,
    input  wire ctl_t                  ctl,
    input  wire logic [COORD_BITS-1:0] acc,
    input  wire logic [COORD_BITS-1:0] cx,
    input  wire logic [COORD_BITS-1:0] cy,
    input  wire logic [COORD_BITS-1:0] px,
    input  wire logic [COORD_BITS-1:0] py,
    input  wire logic [COORD_BITS-1:0] oi,
    input  wire logic [COORD_BITS-1:0] oj,
    output ctl_t                       ctl_n,
    output logic [COORD_BITS-1:0]      acc_n,
    output logic [COORD_BITS-1:0]      cx_n,
    output logic [COORD_BITS-1:0]      cy_n,
    output logic [COORD_BITS-1:0]      px_n,
    output logic [COORD_BITS-1:0]      py_n,
    output logic [COORD_BITS-1:0]      oi_n,
    output logic [COORD_BITS-1:0]      oj_n,
    output res_t                       res,
    output logic                       res_valid
);

    logic [COORD_BITS-1:0] num_val;
    logic                  is_digit;

    assign num_val  = ctl.neg ? (COORD_BITS'(0) - acc) : acc;
    assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);

    always_comb begin
        logic [3:0] mode;
        logic       cont;
        mode      = ctl.mode;
        cont      = !ctl.halted;
        ctl_n     = ctl;
        acc_n     = acc;
        cx_n      = cx;
        cy_n      = cy;
        px_n      = px;
        py_n      = py;
        oi_n      = oi;
        oj_n      = oj;
        res       = '0;
        res_valid = 1'b0;

        // sign of a number
        if (cont && mode == PM_NSTART) begin
            mode = PM_NDIG;
            if (in_byte == CH_MINUS) begin
                ctl_n.neg = 1'b1;
                cont      = 1'b0;
            end
        end

        // digits, or finish the number and fall through
        if (cont && mode == PM_NDIG) begin
            if (is_digit) begin
                acc_n = (acc << 3) + (acc << 1) + COORD_BITS'(in_byte[3:0]);
                cont  = 1'b0;
            end else begin
                mode = PM_IDLE;
                case (ctl.target)
                    TG_X: begin
                        cx_n          = num_val;
                        ctl_n.changed = 1'b1;
                    end
                    TG_Y: begin
                        cy_n          = num_val;
                        ctl_n.changed = 1'b1;
                    end
                    TG_I: begin
                        oi_n          = num_val;
                        ctl_n.changed = 1'b1;
                    end
                    TG_J: begin
                        oj_n          = num_val;
                        ctl_n.changed = 1'b1;
                    end
                    TG_G54: begin
                        ctl_n.tool = num_val[9:0];
                        mode       = PM_SKIP;
                    end
                    default: begin
                        if (num_val == COORD_BITS'(1)) begin
                            ctl_n.expo = EXP_ON;
                        end else if (num_val == COORD_BITS'(2)) begin
                            ctl_n.expo = EXP_OFF;
                        end else if (num_val == COORD_BITS'(3)) begin
                            ctl_n.expo = EXP_FLASH;
                        end else if (!num_val[COORD_BITS-1]
                                     && num_val >= COORD_BITS'(FIRST_TOOL)
                                     && num_val <= COORD_BITS'(LAST_TOOL)) begin
                            ctl_n.tool = num_val[9:0];
                        end else begin
                            ctl_n.halted = 1'b1;
                            res.kind     = KIND_BAD_TOOL;
                            res_valid    = 1'b1;
                            cont         = 1'b0;
                        end
                    end
                endcase
            end
        end

        if (cont) begin
            case (mode)
                PM_G1: begin
                    ctl_n.first = in_byte;
                    mode        = PM_G2;
                end
                PM_G2: begin
                    mode = PM_IDLE;
                    case ({ctl.first, in_byte})
                        CODE_01: ctl_n.interp = IM_LIN_X1;
                        CODE_02: ctl_n.interp = (ctl.interp[2:1] == 2'b11) ? IM_FULL_CW : IM_CW;
                        CODE_03: ctl_n.interp = (ctl.interp[2:1] == 2'b11) ? IM_FULL_CCW : IM_CCW;
                        CODE_10: ctl_n.interp = IM_LIN_X10;
                        CODE_11: ctl_n.interp = IM_LIN_X0P1;
                        CODE_12: ctl_n.interp = IM_LIN_X001;
                        CODE_74: begin
                            if (ctl.interp == IM_FULL_CW) begin
                                ctl_n.interp = IM_CW;
                            end else if (ctl.interp == IM_FULL_CCW) begin
                                ctl_n.interp = IM_CCW;
                            end
                        end
                        CODE_75: begin
                            ctl_n.interp = (ctl.interp == IM_CCW || ctl.interp == IM_FULL_CCW)
                                           ? IM_FULL_CCW : IM_FULL_CW;
                        end
                        CODE_90, CODE_91: ;
                        CODE_00, CODE_04, CODE_36, CODE_37, CODE_70, CODE_71: mode = PM_SKIP;
                        CODE_54: mode = PM_G54D;
                        default: begin
                            ctl_n.halted = 1'b1;
                            res.kind     = KIND_BAD_G;
                            res_valid    = 1'b1;
                        end
                    endcase
                end
                PM_M1: begin
                    ctl_n.first = in_byte;
                    mode        = PM_M2;
                end
                PM_M2: begin
                    mode         = PM_IDLE;
                    ctl_n.halted = 1'b1;
                    res_valid    = 1'b1;
                    if (ctl.first == CH_0 && (in_byte == CH_0 || in_byte == CH_1
                                              || in_byte == CH_2)) begin
                        res.kind = KIND_END;
                    end else begin
                        res.kind = KIND_BAD_M;
                    end
                end
                PM_SKIP: begin
                    if (in_byte == CH_STAR) begin
                        mode = PM_IDLE;
                    end
                end
                PM_PCT: begin
                    if (in_byte == CH_PCT) begin
                        mode = PM_IDLE;
                    end
                end
                PM_G54D: begin
                    if (in_byte == CH_D) begin
                        acc_n        = '0;
                        ctl_n.neg    = 1'b0;
                        ctl_n.target = TG_G54;
                        mode         = PM_NSTART;
                    end else begin
                        mode         = PM_IDLE;
                        ctl_n.halted = 1'b1;
                        res.kind     = KIND_G54_NO_D;
                        res_valid    = 1'b1;
                    end
                end
                default: begin
                    mode = PM_IDLE;
                    case (in_byte)
                        CH_G:   mode = PM_G1;
                        CH_M:   mode = PM_M1;
                        CH_PCT: mode = PM_PCT;
                        CH_D, CH_X, CH_Y, CH_I, CH_J: begin
                            acc_n     = '0;
                            ctl_n.neg = 1'b0;
                            mode      = PM_NSTART;
                            case (in_byte)
                                CH_X:    ctl_n.target = TG_X;
                                CH_Y:    ctl_n.target = TG_Y;
                                CH_I:    ctl_n.target = TG_I;
                                CH_J:    ctl_n.target = TG_J;
                                default: ctl_n.target = TG_D;
                            endcase
                        end
                        CH_STAR: begin
                            if (ctl_n.changed && ctl_n.tool != 10'd0) begin
                                ctl_n.changed   = 1'b0;
                                res_valid       = 1'b1;
                                res.kind        = KIND_SEG;
                                res.start_x     = 32'(px_n);
                                res.start_y     = 32'(py_n);
                                res.end_x       = 32'(cx_n);
                                res.end_y       = 32'(cy_n);
                                res.center_dx   = 32'(oi_n);
                                res.center_dy   = 32'(oj_n);
                                res.interp_mode = ctl_n.interp;
                                res.tool_number = ctl_n.tool;
                                res.exposure    = ctl_n.expo;
                                oi_n            = '0;
                                oj_n            = '0;
                                px_n            = cx_n;
                                py_n            = cy_n;
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
        end

        ctl_n.mode = mode;
    end

endmodule

`default_nettype wire

[rtl/core/gcp_out_reg.sv]
// gcp_out_reg: result register with valid/ready toward the downstream side
// depends on gcp_pkg
`default_nettype none

module gcp_out_reg
    import gcp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  wire res_t res_in,
    input  wire logic m_ready,
    output logic      out_valid,
    output res_t      res_out
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

`default_nettype wire

[rtl/core/gerber_command_stream_parser_core.sv]
// gerber_command_stream_parser_core: rs-274-d command parser, one ascii byte per beat
// input register, parser state, gcp_step logic and gcp_out_reg result stage
// depends on gcp_pkg, gcp_step, gcp_out_reg
//
//   channel | ports              | direction | beat
//   input   | s_valid/s_ready    | in        | s_in_byte
//   result  | m_valid/m_ready    | out       | m_kind .. m_exposure
//
// one byte per cycle sustained while a held result does not stall the step
// a result shows on m_ after its byte passes the input reg, then the result reg
// a byte that gives no result only updates state; nothing is shown for it
// m_ready low with a result held stalls the step; one more byte waits in the input reg
// after a program end or an error every byte is taken and dropped until reset
`default_nettype none

module gerber_command_stream_parser_core
    import gcp_pkg::*;
#(
    parameter int FIRST_TOOL = 10,
    parameter int LAST_TOOL  = 999,
    parameter int COORD_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic signed [31:0] m_start_x,
    output logic signed [31:0] m_start_y,
    output logic signed [31:0] m_end_x,
    output logic signed [31:0] m_end_y,
    output logic signed [31:0] m_center_dx,
    output logic signed [31:0] m_center_dy,
    output logic [2:0]       m_interp_mode,
    output logic [9:0]       m_tool_number,
    output logic [1:0]       m_exposure
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  step_go;

    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [COORD_BITS-1:0] acc_reg, acc_next;
    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic [COORD_BITS-1:0] oi_reg, oi_next;
    logic [COORD_BITS-1:0] oj_reg, oj_next;

    res_t                  step_res;
    logic                  step_res_valid;
    res_t                  out_res;

    assign step_go = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || step_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    gcp_step #(
        .FIRST_TOOL (FIRST_TOOL),
        .LAST_TOOL  (LAST_TOOL),
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .in_byte   (in_byte_reg),
        .ctl       (ctl_reg),
        .acc       (acc_reg),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .px        (px_reg),
        .py        (py_reg),
        .oi        (oi_reg),
        .oj        (oj_reg),
        .ctl_n     (ctl_next),
        .acc_n     (acc_next),
        .cx_n      (cx_next),
        .cy_n      (cy_next),
        .px_n      (px_next),
        .py_n      (py_next),
        .oi_n      (oi_next),
        .oj_n      (oj_next),
        .res       (step_res),
        .res_valid (step_res_valid)
    );

    // an all-zero ctl_t is the idle parse mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg      <= '0;
            acc_reg      <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            oi_reg       <= '0;
            oj_reg       <= '0;
        end else if (step_go) begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
            oi_reg  <= oi_next;
            oj_reg  <= oj_next;
        end
    end

    gcp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_go && step_res_valid),
        .res_in    (step_res),
        .m_ready   (m_ready),
        .out_valid (m_valid),
        .res_out   (out_res)
    );

    assign m_kind        = out_res.kind;
    assign m_start_x     = out_res.start_x;
    assign m_start_y     = out_res.start_y;
    assign m_end_x       = out_res.end_x;
    assign m_end_y       = out_res.end_y;
    assign m_center_dx   = out_res.center_dx;
    assign m_center_dy   = out_res.center_dy;
    assign m_interp_mode = out_res.interp_mode;
    assign m_tool_number = out_res.tool_number;
    assign m_exposure    = out_res.exposure;

endmodule

`default_nettype wire

[rtl/core/gcp_checker.sv]
// gcp_checker: port level assertions for the gerber command stream parser
// bound to gerber_command_stream_parser_core; depends on gcp_pkg
`default_nettype none

module gcp_checker
    import gcp_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [7:0]         s_in_byte,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [2:0]         m_kind,
    input wire logic signed [31:0] m_start_x,
    input wire logic signed [31:0] m_start_y,
    input wire logic signed [31:0] m_end_x,
    input wire logic signed [31:0] m_end_y,
    input wire logic signed [31:0] m_center_dx,
    input wire logic signed [31:0] m_center_dy,
    input wire logic [2:0]         m_interp_mode,
    input wire logic [9:0]         m_tool_number,
    input wire logic [1:0]         m_exposure
);

    // held input beat keeps its byte
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte))
        else $error("input beat changed while stalled");

    // held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_end_x)
            && $stable(m_end_y) && $stable(m_tool_number))
        else $error("result beat changed while stalled");

    // nothing follows a program end or an error
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind != KIND_SEG |=> !m_valid)
        else $error("result after halt");

    // status beats carry only the kind
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_SEG |-> m_start_x == 0 && m_start_y == 0
            && m_end_x == 0 && m_end_y == 0 && m_center_dx == 0 && m_center_dy == 0
            && m_interp_mode == IM_LIN_X1 && m_tool_number == 10'd0
            && m_exposure == EXP_OFF)
        else $error("status beat with nonzero payload");

    // a segment always has an aperture and a legal exposure
    a_seg_tool: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_SEG |-> m_tool_number != 10'd0
            && (m_exposure == EXP_OFF || m_exposure == EXP_ON || m_exposure == EXP_FLASH))
        else $error("segment without aperture or with bad exposure");

endmodule

bind gerber_command_stream_parser_core gcp_checker u_gcp_checker (.*);

`default_nettype wire

[dv/tb_gerber_command_stream_parser_core.sv]
// tb_gerber_command_stream_parser_core: self-checking bench for the gerber command parser
// drives byte beats, predicts segments and errors in-bench, checks every result beat
// depends on gcp_pkg and gerber_command_stream_parser_core
`timescale 1ns / 1ps

module tb_gerber_command_stream_parser_core;
    import gcp_pkg::*;

    localparam int TOOL_LO          = 10;
    localparam int TOOL_HI          = 999;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int BYTES_PER_PHASE  = 100;
    localparam int DROPPED_AFTER_HALT = 40;

    typedef logic [31:0] word_t;

    // d code values with a fixed meaning
    localparam word_t DCODE_ON    = 32'd1;
    localparam word_t DCODE_OFF   = 32'd2;
    localparam word_t DCODE_FLASH = 32'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_in_byte = 8'd0;
    logic        m_ready   = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire [2:0]   m_kind;
    wire signed [31:0] m_start_x;
    wire signed [31:0] m_start_y;
    wire signed [31:0] m_end_x;
    wire signed [31:0] m_end_y;
    wire signed [31:0] m_center_dx;
    wire signed [31:0] m_center_dy;
    wire [2:0]   m_interp_mode;
    wire [9:0]   m_tool_number;
    wire [1:0]   m_exposure;

    int errors         = 0;
    int bytes_sent     = 0;
    int ignored_sent   = 0;
    int send_gap_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;

    res_t plot_events_q[$];

    // parser state as predicted by the bench
    logic [3:0] ps_mode    = PM_IDLE;
    word_t      ps_acc     = '0;
    logic       ps_neg     = 1'b0;
    logic [2:0] ps_target  = TG_X;
    logic [7:0] ps_first   = 8'd0;
    word_t      ps_x       = '0;
    word_t      ps_y       = '0;
    word_t      ps_last_x  = '0;
    word_t      ps_last_y  = '0;
    word_t      ps_i       = '0;
    word_t      ps_j       = '0;
    logic [9:0] ps_tool    = '0;
    logic [1:0] ps_expo    = EXP_OFF;
    logic [2:0] ps_interp  = IM_LIN_X1;
    logic       ps_changed = 1'b0;
    logic       ps_halted  = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    gerber_command_stream_parser_core #(
        .FIRST_TOOL(TOOL_LO),
        .LAST_TOOL (TOOL_HI),
        .COORD_BITS(32)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_start_x    (m_start_x),
        .m_start_y    (m_start_y),
        .m_end_x      (m_end_x),
        .m_end_y      (m_end_y),
        .m_center_dx  (m_center_dx),
        .m_center_dy  (m_center_dy),
        .m_interp_mode(m_interp_mode),
        .m_tool_number(m_tool_number),
        .m_exposure   (m_exposure)
    );

    function automatic void stop_with(input logic [2:0] kind);
        res_t r;
        r = '0;
        r.kind = kind;
        ps_halted = 1'b1;
        plot_events_q.push_back(r);
    endfunction

    function automatic void open_number(input logic [2:0] tgt);
        ps_acc    = '0;
        ps_neg    = 1'b0;
        ps_target = tgt;
        ps_mode   = PM_NSTART;
    endfunction

    function automatic void close_number();
        word_t v;
        v = ps_neg ? (32'd0 - ps_acc) : ps_acc;
        ps_mode = PM_IDLE;
        case (ps_target)
            TG_X: begin
                ps_x = v;
                ps_changed = 1'b1;
            end
            TG_Y: begin
                ps_y = v;
                ps_changed = 1'b1;
            end
            TG_I: begin
                ps_i = v;
                ps_changed = 1'b1;
            end
            TG_J: begin
                ps_j = v;
                ps_changed = 1'b1;
            end
            TG_G54: begin
                ps_tool = v[9:0];
                ps_mode = PM_SKIP;
            end
            default: begin
                if (v == DCODE_ON) ps_expo = EXP_ON;
                else if (v == DCODE_OFF) ps_expo = EXP_OFF;
                else if (v == DCODE_FLASH) ps_expo = EXP_FLASH;
                else if (!v[31] && v >= TOOL_LO && v <= TOOL_HI) ps_tool = v[9:0];
                else stop_with(KIND_BAD_TOOL);
            end
        endcase
    endfunction

    function automatic void decode_gcode(input logic [7:0] second);
        logic full;
        full = (ps_interp == IM_FULL_CW) || (ps_interp == IM_FULL_CCW);
        ps_mode = PM_IDLE;
        case ({ps_first, second})
            CODE_01: ps_interp = IM_LIN_X1;
            CODE_02: ps_interp = full ? IM_FULL_CW : IM_CW;
            CODE_03: ps_interp = full ? IM_FULL_CCW : IM_CCW;
            CODE_10: ps_interp = IM_LIN_X10;
            CODE_11: ps_interp = IM_LIN_X0P1;
            CODE_12: ps_interp = IM_LIN_X001;
            CODE_74: begin
                if (ps_interp == IM_FULL_CW) ps_interp = IM_CW;
                else if (ps_interp == IM_FULL_CCW) ps_interp = IM_CCW;
            end
            CODE_75: begin
                ps_interp = (ps_interp == IM_CCW || ps_interp == IM_FULL_CCW) ?
                            IM_FULL_CCW : IM_FULL_CW;
            end
            CODE_90, CODE_91: ;
            CODE_00, CODE_04, CODE_36, CODE_37, CODE_70, CODE_71: ps_mode = PM_SKIP;
            CODE_54: ps_mode = PM_G54D;
            default: stop_with(KIND_BAD_G);
        endcase
    endfunction

    function automatic void close_block();
        res_t r;
        if (ps_changed && ps_tool != 10'd0) begin
            ps_changed    = 1'b0;
            r             = '0;
            r.kind        = KIND_SEG;
            r.start_x     = ps_last_x;
            r.start_y     = ps_last_y;
            r.end_x       = ps_x;
            r.end_y       = ps_y;
            r.center_dx   = ps_i;
            r.center_dy   = ps_j;
            r.interp_mode = ps_interp;
            r.tool_number = ps_tool;
            r.exposure    = ps_expo;
            plot_events_q.push_back(r);
            ps_i      = '0;
            ps_j      = '0;
            ps_last_x = ps_x;
            ps_last_y = ps_y;
        end
    endfunction

    function automatic void parse_stream_byte(input logic [7:0] b);
        logic again;
        if (ps_halted) return;
        do begin
            again = 1'b0;
            case (ps_mode)
                PM_G1: begin
                    ps_first = b;
                    ps_mode  = PM_G2;
                end
                PM_G2: decode_gcode(b);
                PM_M1: begin
                    ps_first = b;
                    ps_mode  = PM_M2;
                end
                PM_M2: begin
                    ps_mode = PM_IDLE;
                    if ({ps_first, b} == CODE_00 || {ps_first, b} == CODE_01 ||
                        {ps_first, b} == CODE_02) stop_with(KIND_END);
                    else stop_with(KIND_BAD_M);
                end
                PM_SKIP: if (b == CH_STAR) ps_mode = PM_IDLE;
                PM_PCT: if (b == CH_PCT) ps_mode = PM_IDLE;
                PM_G54D: begin
                    if (b == CH_D) open_number(TG_G54);
                    else stop_with(KIND_G54_NO_D);
                end
                PM_NSTART: begin
                    ps_mode = PM_NDIG;
                    if (b == CH_MINUS) ps_neg = 1'b1;
                    else again = 1'b1;
                end
                PM_NDIG: begin
                    if (b >= CH_0 && b <= CH_9) begin
                        ps_acc = ps_acc * 32'd10 + {24'd0, b - CH_0};
                    end else begin
                        close_number();
                        again = !ps_halted;
                    end
                end
                default: begin
                    ps_mode = PM_IDLE;
                    case (b)
                        CH_G: ps_mode = PM_G1;
                        CH_M: ps_mode = PM_M1;
                        CH_D: open_number(TG_D);
                        CH_X: open_number(TG_X);
                        CH_Y: open_number(TG_Y);
                        CH_I: open_number(TG_I);
                        CH_J: open_number(TG_J);
                        CH_PCT: ps_mode = PM_PCT;
                        CH_STAR: close_block();
                        default: ;
                    endcase
                end
            endcase
        end while (again);
    endfunction

    function automatic void check_field(input string name, input word_t want, input word_t got);
        if (want !== got) begin
            errors++;
            $display("%0t  %s: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // result channel: random stalls, compare, quiet-cycle watchdog
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_valid && m_ready) begin
                if (plot_events_q.size() == 0) begin
                    errors++;
                    $display("%0t  unexpected result beat, kind %0d", $time, m_kind);
                end else begin
                    want = plot_events_q.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("start_x", want.start_x, m_start_x);
                    check_field("start_y", want.start_y, m_start_y);
                    check_field("end_x", want.end_x, m_end_x);
                    check_field("end_y", want.end_y, m_end_y);
                    check_field("center_dx", want.center_dx, m_center_dx);
                    check_field("center_dy", want.center_dy, m_center_dy);
                    check_field("interp_mode", want.interp_mode, m_interp_mode);
                    check_field("tool_number", want.tool_number, m_tool_number);
                    check_field("exposure", want.exposure, m_exposure);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t  no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_stream_byte(b);
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // filler bytes; avoid (a terminator or a minus sign) is kept out, and at top level so are G, M, D and %
    task automatic send_junk(input int n, input bit top_level, input logic [7:0] avoid);
        logic [7:0] b;
        repeat (n) begin
            do b = $urandom_range(255);
            while (b == avoid || (top_level && (b == CH_G || b == CH_M || b == CH_D ||
                                                 b == CH_PCT)));
            send_byte(b);
            ignored_sent++;
        end
    endtask

    function automatic string number_text();
        string t;
        int n;
        t = "";
        if ($urandom_range(3) == 0) t = "-";
        case ($urandom_range(19))
            0: n = 0;
            1: n = $urandom_range(11, 14);
            2: return {t, $sformatf("%0d", $urandom())};
            default: n = $urandom_range(1, 7);
        endcase
        for (int i = 0; i < n; i++) t = {t, $sformatf("%0d", $urandom_range(9))};
        return t;
    endfunction

    function automatic string mode_gcode();
        case ($urandom_range(7))
            0: return "G01";
            1: return "G02";
            2: return "G03";
            3: return "G10";
            4: return "G11";
            5: return "G12";
            6: return "G74";
            default: return "G75";
        endcase
    endfunction

    function automatic string skip_gcode();
        case ($urandom_range(5))
            0: return "G00";
            1: return "G04";
            2: return "G36";
            3: return "G37";
            4: return "G70";
            default: return "G71";
        endcase
    endfunction

    function automatic string exposure_dcode();
        case ($urandom_range(5))
            0: return "D1";
            1: return "D2";
            2: return "D3";
            3: return "D01";
            4: return "D02";
            default: return "D03";
        endcase
    endfunction

    function automatic string tool_dcode();
        string p;
        p = "D";
        if ($urandom_range(3) == 0) p = "D0";
        return {p, $sformatf("%0d", $urandom_range(TOOL_LO, TOOL_HI))};
    endfunction

    task automatic send_coord_block();
        if ($urandom_range(1)) send_str(mode_gcode());
        if ($urandom_range(99) < 60) send_str({"X", number_text()});
        if ($urandom_range(99) < 60) send_str({"Y", number_text()});
        if ($urandom_range(9) == 0) send_junk(1, 1'b1, CH_MINUS);
        if ($urandom_range(99) < 40) send_str({"I", number_text()});
        if ($urandom_range(99) < 40) send_str({"J", number_text()});
        if ($urandom_range(3) == 0) send_str(exposure_dcode());
        if ($urandom_range(7) == 0) send_str(tool_dcode());
        send_str("*");
    endtask

    task automatic send_random_block();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_coord_block();
        end else if (pick < 65) begin
            send_str({tool_dcode(), "*"});
        end else if (pick < 72) begin
            send_str(skip_gcode());
            send_junk($urandom_range(0, 8), 1'b0, CH_STAR);
            send_str("*");
        end else if (pick < 77) begin
            send_str({"G54D", number_text()});
            send_junk($urandom_range(0, 3), 1'b0, CH_STAR);
            send_str("*");
        end else if (pick < 83) begin
            send_str("%");
            send_junk($urandom_range(0, 10), 1'b0, CH_PCT);
            send_str("%");
        end else if (pick < 89) begin
            case ($urandom_range(2))
                0: send_str("*");
                1: send_str("G90*");
                default: send_str("G91");
            endcase
        end else begin
            send_junk($urandom_range(1, 6), 1'b1, CH_STAR);
        end
    endtask

    task automatic test_star_and_tool_zero();
        send_str("*X5*");
        send_str("%FSLAX23Y23*%");
        send_str("D10*");
        send_str("*");
    endtask

    task automatic test_number_forms();
        send_str("X-0Y-*");
        send_str("X2147483647Y-2147483648I-1J1*");
        send_str("X4294967296Y99999999999*");
        send_str("XY-I*");
        send_str("X 12*X--7*");
    endtask

    task automatic test_dcodes();
        send_str("D01X1*D2X2*D003X3*D999X4*D10Y1*");
    endtask

    task automatic test_gcodes();
        send_str("G01X1*G10X2*G11X3*G12X4*G02X5I1J1*G03X6*");
        send_str("G75G02X7*G03X8*G74X9*G03G75X10*G74G01G75X11*G90G91X12*");
        send_str("G04 comment D M G*G00X99*G36*G37*G70*G71*");
        send_str("G54D12*X13*G54D1034X5*X14*G54D0*X15*D11*G54D-1*X16*D10*");
    endtask

    task automatic test_byte_range();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_str("X1*");
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        int first;
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        first = bytes_sent - ignored_sent;
        while (bytes_sent - ignored_sent - first < BYTES_PER_PHASE) send_random_block();
    endtask

    // one terminating command per run, since the block stays halted until reset
    task automatic test_halt_and_drop();
        send_gap_pct   = 34;
        sink_stall_pct = 34;
        case ($urandom_range(12))
            0: send_str("M00");
            1: send_str("M01");
            2: send_str("M02*");
            3: send_str("M07");
            4: send_str("MX2");
            5: send_str("G99");
            6: send_str("G5A");
            7: send_str("G54X");
            8: send_str("D5*");
            9: send_str("D-3*");
            10: send_str("D1000*");
            11: send_str("D0*");
            default: send_str("D99999999999*");
        endcase
        repeat (DROPPED_AFTER_HALT) send_byte($urandom_range(255));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_star_and_tool_zero();
        test_number_forms();
        test_dcodes();
        test_gcodes();
        test_byte_range();
        test_random_phase(0, 0);
        test_random_phase(88, 0);
        test_random_phase(0, 88);
        test_random_phase(34, 34);
        test_halt_and_drop();
        s_valid <= 1'b0;
        while (plot_events_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (plot_events_q.size() != 0) begin
            errors++;
            $display("%0t  %0d results never arrived", $time, plot_events_q.size());
        end
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
